>>> sv/kowt_pkg.sv
// ----------------------------------------------------------------------------
// Keyed order wait time calculator package
// Shared widths, the controller state type and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kowt_pkg;

   localparam int MAX_PROCESSES_DEF = 32;

   localparam int ID_W   = 8;
   localparam int TIME_W = 16;
   localparam int PRIO_W = 8;
   localparam int SUM_W  = 22;
   localparam int MODE_W = 2;

   localparam int REC_W      = ID_W + 2 * TIME_W + PRIO_W;
   localparam int REQ_DATA_W = ((REC_W + 7) / 8) * 8;
   localparam int RSP_USED_W = ID_W + 2 * SUM_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_ARRIVAL  = 2'd0,
      MODE_BURST    = 2'd1,
      MODE_PRIORITY = 2'd2
   } order_mode_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_clear;
      logic scan_run;
      logic result_load;
      logic result_taken;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
      logic out_last;
   } status_type;

endpackage

`default_nettype wire

>>> sv/kowt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kowt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/kowt_ctrl.sv
// ----------------------------------------------------------------------------
// Keyed order wait time calculator controller
// Sequences loading, the selection scans and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module kowt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  kowt_pkg::status_type status,
   output kowt_pkg::cmd_type    cmd
);

   import kowt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  cmd.scan_clear = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            cmd.result_load = 1'b1;
            state_in        = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.result_taken = 1'b1;
               if (status.out_last) begin
                  state_in = ST_LOAD;
               end else begin
                  cmd.scan_clear = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> sv/kowt_dp.sv
// ----------------------------------------------------------------------------
// Keyed order wait time calculator datapath
// Process table, selection scan for the next record in key order, and the
// saturating waiting and turnaround sums.
// ----------------------------------------------------------------------------
`default_nettype none

module kowt_dp #(
   parameter int MAX_PROCESSES = kowt_pkg::MAX_PROCESSES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  kowt_pkg::cmd_type               cmd,
   output kowt_pkg::status_type            status,
   input  logic                            csr_valid,
   input  logic [kowt_pkg::MODE_W-1:0]     csr_data,
   input  logic [kowt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic [kowt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   import kowt_pkg::*;

   localparam int AW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CW = $clog2(MAX_PROCESSES + 1);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     emitted_ff, emitted_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic              rd_vld_ff;
   logic [AW-1:0]     rd_idx_ff;
   logic              best_found_ff, best_found_in;
   logic [TIME_W-1:0] best_key_ff, best_key_in;
   logic [AW-1:0]     best_idx_ff, best_idx_in;
   logic [ID_W-1:0]   best_id_ff, best_id_in;
   logic [TIME_W-1:0] best_burst_ff, best_burst_in;
   logic              prev_valid_ff, prev_valid_in;
   logic [TIME_W-1:0] prev_key_ff, prev_key_in;
   logic [AW-1:0]     prev_idx_ff, prev_idx_in;
   logic [SUM_W-1:0]  elapsed_ff, elapsed_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [SUM_W-1:0]  rsp_turn_ff, rsp_turn_in;
   logic [SUM_W-1:0]  rsp_wait_ff, rsp_wait_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              wr_en;
   logic [REC_W-1:0]  rd_data;
   logic [ID_W-1:0]   rd_id;
   logic [TIME_W-1:0] rd_arrival;
   logic [TIME_W-1:0] rd_burst;
   logic [PRIO_W-1:0] rd_prio;
   logic [TIME_W-1:0] rd_key;
   logic              take;
   logic [SUM_W:0]    sum;
   logic [SUM_W-1:0]  turn;

   assign wr_en = cmd.load && (count_ff < CW'(MAX_PROCESSES));

   kowt_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_PROCESSES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata[REC_W-1:0]),
      .rd_en   (cmd.scan_run),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rd_id      = rd_data[ID_W-1:0];
   assign rd_arrival = rd_data[ID_W +: TIME_W];
   assign rd_burst   = rd_data[ID_W + TIME_W +: TIME_W];
   assign rd_prio    = rd_data[ID_W + 2 * TIME_W +: PRIO_W];

   always_comb begin
      case (mode_ff)
         MODE_BURST:    rd_key = rd_burst;
         MODE_PRIORITY: rd_key = TIME_W'(rd_prio);
         default:       rd_key = rd_arrival;
      endcase
   end

   assign take = rd_vld_ff
      && (!prev_valid_ff || ({rd_key, rd_idx_ff} > {prev_key_ff, prev_idx_ff}))
      && (!best_found_ff || ({rd_key, rd_idx_ff} < {best_key_ff, best_idx_ff}));

   assign sum  = {1'b0, elapsed_ff} + (SUM_W + 1)'(best_burst_ff);
   assign turn = sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];

   assign status.scan_end = (CW'(addr_ff) + CW'(1)) == count_ff;
   assign status.out_last = (emitted_ff + CW'(1)) == count_ff;

   always_comb begin
      mode_in       = csr_valid ? csr_data : mode_ff;
      count_in      = count_ff;
      emitted_in    = emitted_ff;
      addr_in       = addr_ff;
      best_found_in = best_found_ff;
      best_key_in   = best_key_ff;
      best_idx_in   = best_idx_ff;
      best_id_in    = best_id_ff;
      best_burst_in = best_burst_ff;
      prev_valid_in = prev_valid_ff;
      prev_key_in   = prev_key_ff;
      prev_idx_in   = prev_idx_ff;
      elapsed_in    = elapsed_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_turn_in   = rsp_turn_ff;
      rsp_wait_in   = rsp_wait_ff;
      rsp_last_in   = rsp_last_ff;

      if (wr_en) begin
         count_in = count_ff + CW'(1);
      end

      if (cmd.scan_clear) begin
         addr_in       = '0;
         best_found_in = 1'b0;
      end else begin
         if (cmd.scan_run) begin
            addr_in = addr_ff + AW'(1);
         end
         if (take) begin
            best_found_in = 1'b1;
            best_key_in   = rd_key;
            best_idx_in   = rd_idx_ff;
            best_id_in    = rd_id;
            best_burst_in = rd_burst;
         end
      end

      if (cmd.result_load) begin
         rsp_id_in   = best_id_ff;
         rsp_wait_in = elapsed_ff;
         rsp_turn_in = turn;
         rsp_last_in = status.out_last;
      end

      if (cmd.result_taken) begin
         if (rsp_last_ff) begin
            count_in      = '0;
            emitted_in    = '0;
            elapsed_in    = '0;
            prev_valid_in = 1'b0;
         end else begin
            emitted_in    = emitted_ff + CW'(1);
            elapsed_in    = rsp_turn_ff;
            prev_valid_in = 1'b1;
            prev_key_in   = best_key_ff;
            prev_idx_in   = best_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_ARRIVAL;
         count_ff      <= '0;
         emitted_ff    <= '0;
         addr_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         prev_valid_ff <= 1'b0;
         elapsed_ff    <= '0;
      end else begin
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         emitted_ff    <= emitted_in;
         addr_ff       <= addr_in;
         rd_vld_ff     <= cmd.scan_run;
         best_found_ff <= best_found_in;
         prev_valid_ff <= prev_valid_in;
         elapsed_ff    <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= addr_ff;
      best_key_ff   <= best_key_in;
      best_idx_ff   <= best_idx_in;
      best_id_ff    <= best_id_in;
      best_burst_ff <= best_burst_in;
      prev_key_ff   <= prev_key_in;
      prev_idx_ff   <= prev_idx_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_turn_ff   <= rsp_turn_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tdata = {{(RSP_DATA_W - RSP_USED_W){1'b0}}, rsp_wait_ff, rsp_turn_ff, rsp_id_ff};
   assign rsp_tlast = rsp_last_ff;

endmodule

`default_nettype wire

>>> sv/keyed_order_wait_time_calc.sv
// ----------------------------------------------------------------------------
// Keyed order wait time calculator
// Non-preemptive FCFS, SJF and priority scheduling of a loaded process set.
//
// Process records arrive on the req stream, one item per cycle while the
// block is loading; the item with tlast closes the set. Records beyond
// MAX_PROCESSES are dropped. The csr channel writes the sort key mode and
// is always ready.
// After the closing item the block finds each next record in key order by
// scanning the process table, one entry per cycle on the table's read port.
// For each result the block scans all n loaded records, finishes the last
// read, loads the output register and hands the item over; the whole set is
// scanned again for every result.
// One result at a time is held in the output register until rsp_tready
// is seen; a stalled receiver simply holds the block, and no new set is
// loaded until the last result of the current one is taken.
// Reset returns the block to loading with an empty table, zero sums and
// mode arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_order_wait_time_calc #(
   parameter int MAX_PROCESSES = kowt_pkg::MAX_PROCESSES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // csr_data: order_mode
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kowt_pkg::MODE_W-1:0]     csr_data,
   // req_tdata: process_id, arrival_time, burst_time, priority_req
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kowt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   // rsp_tdata: result_id, turnaround, waiting
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kowt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   import kowt_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   kowt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kowt_dp #(
      .MAX_PROCESSES (MAX_PROCESSES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("Loading and result delivery overlap.");

   a_close_set: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("Block still loading after the closing item.");

   a_reopen: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("Block not loading after the final result.");

   a_turn_ge_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[29:8] >= rsp_tdata[51:30]))
      else $error("Turnaround below waiting time.");

endmodule

`default_nettype wire

>>> tb/tb_keyed_order_wait_time_calc.sv
// ----------------------------------------------------------------------------
// Testbench for the keyed order wait time calculator
// Loads process sets over the req stream and checks every scheduled result
// on the rsp stream against a scheduler written in the testbench. A short
// table of directed sets comes first: extremes, each order mode, the unused
// mode, equal keys and the mode after reset. Random sets follow, among them
// a full table and one that overflows it. The sender idles in bursts and
// the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_keyed_order_wait_time_calc;
   import kowt_pkg::*;

   localparam int MAX_PROC = MAX_PROCESSES_DEF;
   localparam int RAND_ITEMS = 100;
   localparam int SETTLE = 40;
   localparam int WATCHDOG = 2000;
   localparam int DIR_N = 19;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] arrival;
      logic [ID_W-1:0]   id;
   } proc_rec;

   typedef struct packed {
      logic [RSP_DATA_W-RSP_USED_W-1:0] pad;
      logic [SUM_W-1:0]                 waiting;
      logic [SUM_W-1:0]                 turnaround;
      logic [ID_W-1:0]                  id;
   } rsp_word;

   typedef struct {
      logic [ID_W-1:0]  id;
      logic [SUM_W-1:0] turnaround;
      logic [SUM_W-1:0] waiting;
      logic             last;
   } sched_entry;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              first;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [PRIO_W-1:0] prio;
      logic              last;
      logic              typed;
      logic [SUM_W-1:0]  turn;
   } dir_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [MODE_W-1:0]     csr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   proc_rec           held_tab [MAX_PROC];
   int                held_cnt = 0;
   logic [MODE_W-1:0] sort_mode = MODE_ARRIVAL;
   sched_entry        sched_q [$];
   int                mismatch_cnt = 0;
   int                idle_cycles = 0;
   int                burst_left = 0;
   logic              steady = 1'b0;
   int unsigned       stall_cnt = 0;
   int unsigned       stall_style = 0;
   dir_row            dir_tab [DIR_N];

   keyed_order_wait_time_calc #(
      .MAX_PROCESSES(MAX_PROC)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [TIME_W-1:0] key_of(input proc_rec r);
      case (sort_mode)
         MODE_BURST:    return r.burst;
         MODE_PRIORITY: return {{(TIME_W-PRIO_W){1'b0}}, r.prio};
         default:       return r.arrival;
      endcase
   endfunction

   // Stores one record and, on the closing item, queues the whole schedule.
   task automatic load_record(input proc_rec r, input logic last, input logic typed,
                              input logic [SUM_W-1:0] turn);
      int         ord [MAX_PROC];
      int         i;
      int         j;
      logic [TIME_W-1:0] k;
      logic [SUM_W:0]    acc;
      logic [SUM_W:0]    sum;
      sched_entry e;
      if (held_cnt < MAX_PROC) begin
         held_tab[held_cnt] = r;
         held_cnt++;
      end
      if (last) begin
         if (typed) begin
            e.id = r.id;
            e.turnaround = turn;
            e.waiting = '0;
            e.last = 1'b1;
            sched_q.push_back(e);
         end else begin
            for (i = 0; i < held_cnt; i++) begin
               k = key_of(held_tab[i]);
               j = i;
               while (j > 0 && key_of(held_tab[ord[j-1]]) > k) begin
                  ord[j] = ord[j-1];
                  j--;
               end
               ord[j] = i;
            end
            acc = '0;
            for (i = 0; i < held_cnt; i++) begin
               sum = acc + held_tab[ord[i]].burst;
               if (sum > SUM_MAX) sum = SUM_MAX;
               e.id = held_tab[ord[i]].id;
               e.waiting = acc[SUM_W-1:0];
               e.turnaround = sum[SUM_W-1:0];
               e.last = (i == held_cnt - 1);
               sched_q.push_back(e);
               acc = sum;
            end
         end
         held_cnt = 0;
      end
   endtask

   task automatic send_record(input proc_rec r, input logic last, input logic typed,
                              input logic [SUM_W-1:0] turn);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= r;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      load_record(r, last, typed, turn);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sched_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] m);
      csr_valid <= 1'b1;
      csr_data <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sort_mode = m;
   endtask

   function automatic logic [TIME_W-1:0] pick_time();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return TIME_W'($urandom_range(0, 3));
         default: return TIME_W'($urandom);
      endcase
   endfunction

   function automatic logic [PRIO_W-1:0] pick_prio();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return PRIO_W'($urandom_range(0, 3));
         default: return PRIO_W'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 0) stall_style <= $urandom_range(0, 3);
      case (stall_style)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= (stall_cnt % 8 == 0);
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_word    got;
      sched_entry want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (sched_q.size() == 0) begin
               if (mismatch_cnt < 10)
                  $display("Unexpected result: id %0h turnaround %0d waiting %0d last %0b",
                           got.id, got.turnaround, got.waiting, rsp_tlast);
               mismatch_cnt <= mismatch_cnt + 1;
            end else begin
               want = sched_q.pop_front();
               if (got.id !== want.id || got.turnaround !== want.turnaround ||
                   got.waiting !== want.waiting || rsp_tlast !== want.last ||
                   got.pad !== '0) begin
                  if (mismatch_cnt < 10)
                     $display({"Mismatch: expected id %0h turnaround %0d waiting %0d last %0b,",
                               " got id %0h turnaround %0d waiting %0d last %0b pad %0h"},
                              want.id, want.turnaround, want.waiting, want.last,
                              got.id, got.turnaround, got.waiting, rsp_tlast, got.pad);
                  mismatch_cnt <= mismatch_cnt + 1;
               end
            end
         end
      end
   end

   initial begin
      proc_rec r;
      int      sent;
      int      set_no;
      int      size;
      int      k;
      dir_tab = '{
         '{MODE_ARRIVAL,  1'b1, 8'h00, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, 22'd0},
         '{MODE_ARRIVAL,  1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 22'd65535},
         '{MODE_BURST,    1'b1, 8'h5A, 16'h1234, 16'hFFFF, 8'h00, 1'b1, 1'b1, 22'd65535},
         '{MODE_BURST,    1'b1, 8'h01, 16'd100,  16'd300,  8'd9,  1'b0, 1'b0, 22'd0},
         '{MODE_BURST,    1'b0, 8'h02, 16'd50,   16'd100,  8'd3,  1'b0, 1'b0, 22'd0},
         '{MODE_BURST,    1'b0, 8'h03, 16'd10,   16'd300,  8'd1,  1'b0, 1'b0, 22'd0},
         '{MODE_BURST,    1'b0, 8'h04, 16'd5,    16'd0,    8'd7,  1'b1, 1'b0, 22'd0},
         '{MODE_PRIORITY, 1'b1, 8'h10, 16'd0,    16'd1000, 8'd200, 1'b0, 1'b0, 22'd0},
         '{MODE_PRIORITY, 1'b0, 8'h11, 16'd1,    16'd2000, 8'd0,  1'b0, 1'b0, 22'd0},
         '{MODE_PRIORITY, 1'b0, 8'h12, 16'd2,    16'd3000, 8'hFF, 1'b0, 1'b0, 22'd0},
         '{MODE_PRIORITY, 1'b0, 8'h13, 16'd3,    16'd4000, 8'd0,  1'b1, 1'b0, 22'd0},
         '{MODE_UNUSED,   1'b1, 8'h20, 16'hFFFF, 16'd10,   8'd1,  1'b0, 1'b0, 22'd0},
         '{MODE_UNUSED,   1'b0, 8'h21, 16'h0000, 16'd20,   8'd2,  1'b0, 1'b0, 22'd0},
         '{MODE_UNUSED,   1'b0, 8'h22, 16'h8000, 16'hFFFF, 8'd3,  1'b0, 1'b0, 22'd0},
         '{MODE_UNUSED,   1'b0, 8'h23, 16'h0000, 16'hFFFF, 8'd4,  1'b1, 1'b0, 22'd0},
         '{MODE_ARRIVAL,  1'b1, 8'hA0, 16'h0042, 16'hFFFF, 8'h80, 1'b0, 1'b0, 22'd0},
         '{MODE_ARRIVAL,  1'b0, 8'hA1, 16'h0042, 16'hFFFF, 8'h01, 1'b0, 1'b0, 22'd0},
         '{MODE_ARRIVAL,  1'b0, 8'hA2, 16'h0042, 16'hFFFF, 8'h02, 1'b0, 1'b0, 22'd0},
         '{MODE_ARRIVAL,  1'b0, 8'hA3, 16'h0042, 16'd1,    8'h03, 1'b1, 1'b0, 22'd0}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The first set runs on the mode left by reset.
      for (int i = 0; i < DIR_N; i++) begin
         if (dir_tab[i].first) begin
            steady = 1'($urandom_range(0, 1));
            wait_idle();
            if (i != 0) write_mode(dir_tab[i].mode);
         end
         r.id = dir_tab[i].id;
         r.arrival = dir_tab[i].arrival;
         r.burst = dir_tab[i].burst;
         r.prio = dir_tab[i].prio;
         send_record(r, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].turn);
      end

      // Set two fills the table exactly and set five overflows it.
      sent = 0;
      set_no = 0;
      while (sent < RAND_ITEMS || set_no < 6) begin
         if (set_no == 2)
            size = MAX_PROC;
         else if (set_no == 5)
            size = $urandom_range(MAX_PROC + 1, MAX_PROC + 4);
         else if ($urandom_range(0, 5) == 0)
            size = $urandom_range(9, 16);
         else
            size = $urandom_range(1, 8);
         if (set_no == 0 || $urandom_range(0, 1) == 1) begin
            wait_idle();
            write_mode(MODE_W'($urandom_range(0, 3)));
         end
         steady = ($urandom_range(0, 3) == 0);
         for (k = 0; k < size; k++) begin
            r.id = ID_W'($urandom);
            r.arrival = pick_time();
            r.burst = pick_time();
            r.prio = pick_prio();
            send_record(r, k == size - 1, 1'b0, '0);
            sent++;
         end
         set_no++;
      end

      wait_idle();
      if (mismatch_cnt == 0 && sched_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
